// ----- src/ntsc_line_timing_and_pixel_fetch_top_defines.svh -----
// assertion macros for the scan-line timing and pixel fetch block
// used by the checker bound to the top level; no other dependencies
`ifndef NTSC_LINE_TIMING_AND_PIXEL_FETCH_TOP_DEFINES_SVH
`define NTSC_LINE_TIMING_AND_PIXEL_FETCH_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define NTLT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NTLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ntlt_pkg.sv -----
// shared types, constants and helpers for the scan-line timing and pixel fetch block
// no dependencies
package ntlt_pkg;

	// field widths
	localparam int LINE_W      = 9;
	localparam int SYNC_W      = 10;
	localparam int PIX_W       = 8;
	localparam int IN_ADDR_W   = 10;
	localparam int REP_W       = 3;
	localparam int CFG_DATA_W  = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	// default geometry of the frame store
	localparam int BYTES_PER_LINE_DEF = 11;
	localparam int STORED_LINES_DEF   = 80;

	// raster timing
	localparam int LINES_PER_FIELD  = 262;
	localparam int VISIBLE_LINES    = 240;
	localparam int VSYNC_FIRST_LINE = 245;
	localparam int VSYNC_END_LINE   = 248;
	localparam int MAX_REPEAT       = 4;

	// queue depths
	localparam int Q_DEPTH   = 4;
	localparam int OUT_DEPTH = 4;

	// configuration reset values
	localparam logic [SYNC_W-1:0] HSYNC_RESET  = 10'd35;
	localparam logic [SYNC_W-1:0] VSYNC_RESET  = 10'd435;
	localparam logic [REP_W-1:0]  REPEAT_RESET = 3'd3;
	localparam logic              INVERT_RESET = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HSYNC_WIDTH   = 2'd0,
		REG_VSYNC_WIDTH   = 2'd1,
		REG_LINE_REPEAT   = 2'd2,
		REG_INVERT_PIXELS = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [SYNC_W-1:0] hsync_width;
		logic [SYNC_W-1:0] vsync_width;
		logic [REP_W-1:0]  line_repeat;
		logic              invert_pixels;
	} cfg_t;

	// one classified input item waiting for the back end
	typedef struct packed {
		logic                 is_write;
		logic [IN_ADDR_W-1:0] addr;
		logic [PIX_W-1:0]     data;
	} q_item_t;

	// one result item
	typedef struct packed {
		logic [LINE_W-1:0] line_number;
		logic [SYNC_W-1:0] sync_width;
		logic [PIX_W-1:0]  pixel_byte;
		logic              pixel_valid;
		logic              last;
	} out_item_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ----- src/ntlt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// depends on ntlt_pkg for the address width helper
module ntlt_ram import ntlt_pkg::*; #(
	parameter int WIDTH = PIX_W,
	parameter int DEPTH = BYTES_PER_LINE_DEF * STORED_LINES_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [addr_bits(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]            wdata,
	input  logic                        re,
	input  logic [addr_bits(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/ntlt_front.sv -----
// front end: accepts input transactions, drops out-of-range writes, queues the rest
// depends on ntlt_pkg
module ntlt_front import ntlt_pkg::*; #(
	parameter int STORE_BYTES = BYTES_PER_LINE_DEF * STORED_LINES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  logic                 s_func,
	input  logic [IN_ADDR_W-1:0] s_addr,
	input  logic [PIX_W-1:0]     s_data,
	input  logic                 clearing,
	output logic                 q_valid,
	output q_item_t              q_item,
	input  logic                 q_pop
);

	localparam int Q_PW = addr_bits(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);
	localparam int SB_W = $clog2(STORE_BYTES + 1);
	localparam int CW   = (SB_W > IN_ADDR_W) ? SB_W : IN_ADDR_W;

	q_item_t          q_mem_q [Q_DEPTH];
	logic [Q_PW-1:0]  wr_ptr_q;
	logic [Q_PW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  cnt_q;
	logic             accept;
	logic             in_range;
	logic             push;

	assign s_ready  = (cnt_q != Q_CW'(Q_DEPTH)) && !clearing;
	assign accept   = s_valid && s_ready;
	assign in_range = CW'(s_addr) < CW'(STORE_BYTES);
	// writes outside the store are taken and forgotten
	assign push     = accept && (!s_func || in_range);

	assign q_valid = (cnt_q != '0);
	assign q_item  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{is_write: s_func, addr: s_addr, data: s_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + Q_CW'(push) - Q_CW'(q_pop);
		end
	end

endmodule

// ----- src/ntlt_back.sv -----
// back end: frame store, line state, byte sequencer and result queue
// depends on ntlt_pkg and ntlt_ram
module ntlt_back import ntlt_pkg::*; #(
	parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF,
	parameter int STORED_LINES   = STORED_LINES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  q_item_t   q_item,
	output logic      q_pop,
	output logic      clearing,
	output logic      m_valid,
	input  logic      m_ready,
	output out_item_t m_item
);

	localparam int STORE_BYTES = BYTES_PER_LINE * STORED_LINES;
	localparam int AW     = addr_bits(STORE_BYTES);
	localparam int BW     = $clog2(BYTES_PER_LINE + 1);
	localparam int OUT_PW = addr_bits(OUT_DEPTH);
	localparam int OUT_CW = $clog2(OUT_DEPTH + 2);

	// line state
	logic [LINE_W-1:0] line_q;
	logic [1:0]        rep_q;
	logic [AW-1:0]     ptr_q;

	// clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// current tick
	logic              busy_q;
	logic [BW-1:0]     beat_q;
	logic [LINE_W-1:0] tick_line_q;
	logic [SYNC_W-1:0] tick_sync_q;
	logic              tick_vis_q;
	logic [AW-1:0]     tick_base_q;

	// read stage
	logic              v_s1;
	logic [LINE_W-1:0] line_s1;
	logic [SYNC_W-1:0] sync_s1;
	logic              vis_s1;
	logic              last_s1;
	logic              ram_s1;
	logic              inv_s1;

	// result queue
	out_item_t         out_mem_q [OUT_DEPTH];
	logic [OUT_PW-1:0] out_wr_q;
	logic [OUT_PW-1:0] out_rd_q;
	logic [OUT_CW-1:0] out_cnt_q;

	logic              credit_ok;
	logic              issue;
	logic              last_beat;
	logic              use_ram;
	logic              pop_tick;
	logic              pop_write;
	logic              cur_vis;
	logic [SYNC_W-1:0] cur_sync;
	logic [REP_W-1:0]  reps_eff;
	logic              rep_more;
	logic [AW:0]       ptr_sum;
	logic [AW-1:0]     ptr_next;
	logic [LINE_W-1:0] line_next;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [PIX_W-1:0]  ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [PIX_W-1:0]  ram_rdata;
	logic [PIX_W-1:0]  pix_s1;
	logic              out_pop;

	assign clearing = clr_q;

	// a beat may issue only if the result queue has room for it and all in flight
	assign credit_ok = (out_cnt_q + OUT_CW'(v_s1)) < OUT_CW'(OUT_DEPTH);
	assign issue     = busy_q && credit_ok;
	assign last_beat = !tick_vis_q || (beat_q == BW'(BYTES_PER_LINE));
	assign use_ram   = tick_vis_q && (beat_q != BW'(BYTES_PER_LINE));

	// next item may start while the last beat of the current tick goes out
	assign q_pop     = q_valid && !clr_q && (!busy_q || (issue && last_beat));
	assign pop_tick  = q_pop && !q_item.is_write;
	assign pop_write = q_pop && q_item.is_write;

	assign cur_vis  = line_q < LINE_W'(VISIBLE_LINES);
	assign cur_sync = ((line_q >= LINE_W'(VSYNC_FIRST_LINE)) && (line_q < LINE_W'(VSYNC_END_LINE)))
		? cfg.vsync_width : cfg.hsync_width;

	always_comb begin
		priority if (cfg.line_repeat == '0) begin
			reps_eff = REP_W'(1);
		end else if (cfg.line_repeat > REP_W'(MAX_REPEAT)) begin
			reps_eff = REP_W'(MAX_REPEAT);
		end else begin
			reps_eff = cfg.line_repeat;
		end
	end

	assign rep_more  = ({1'b0, rep_q} + REP_W'(1)) < reps_eff;
	assign ptr_sum   = {1'b0, ptr_q} + (AW + 1)'(BYTES_PER_LINE);
	assign ptr_next  = (ptr_sum >= (AW + 1)'(STORE_BYTES)) ? '0 : ptr_sum[AW-1:0];
	assign line_next = (line_q == LINE_W'(LINES_PER_FIELD - 1)) ? '0 : line_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q     <= '0;
			rep_q      <= '0;
			ptr_q      <= '0;
			busy_q     <= 1'b0;
			beat_q     <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (pop_tick) begin
				busy_q <= 1'b1;
				beat_q <= '0;
				line_q <= line_next;
				if (cur_vis) begin
					if (rep_more) begin
						rep_q <= rep_q + 1'b1;
					end else begin
						rep_q <= '0;
						ptr_q <= ptr_next;
					end
				end else if (line_q == LINE_W'(VSYNC_FIRST_LINE)) begin
					rep_q <= '0;
					ptr_q <= '0;
				end
			end else if (issue) begin
				if (last_beat) begin
					busy_q <= 1'b0;
				end else begin
					beat_q <= beat_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_tick) begin
			tick_line_q <= line_q;
			tick_sync_q <= cur_sync;
			tick_vis_q  <= cur_vis;
			tick_base_q <= ptr_q;
		end
	end

	// frame store
	assign ram_we    = clr_q || pop_write;
	assign ram_waddr = clr_q ? clr_addr_q : AW'(q_item.addr);
	assign ram_wdata = clr_q ? '0 : q_item.data;
	assign ram_raddr = tick_base_q + AW'(beat_q);

	ntlt_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue && use_ram),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			line_s1 <= tick_line_q;
			sync_s1 <= tick_sync_q;
			vis_s1  <= tick_vis_q;
			last_s1 <= last_beat;
			ram_s1  <= use_ram;
			inv_s1  <= cfg.invert_pixels;
		end
	end

	// closing and blank bytes are zero, never inverted
	assign pix_s1 = ram_s1 ? (inv_s1 ? ~ram_rdata : ram_rdata) : '0;

	// result queue
	assign m_valid = (out_cnt_q != '0);
	assign m_item  = out_mem_q[out_rd_q];
	assign out_pop = m_valid && m_ready;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			out_mem_q[out_wr_q] <= '{
				line_number: line_s1,
				sync_width:  sync_s1,
				pixel_byte:  pix_s1,
				pixel_valid: vis_s1,
				last:        last_s1
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (v_s1) begin
				out_wr_q <= (out_wr_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : out_wr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_q <= (out_rd_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : out_rd_q + 1'b1;
			end
			out_cnt_q <= out_cnt_q + OUT_CW'(v_s1) - OUT_CW'(out_pop);
		end
	end

endmodule

// ----- src/ntsc_line_timing_and_pixel_fetch_top.sv -----
// a tick's first result passes the input queue, the tick registers, the read stage and the
// result queue before it is presented; a visible-line tick gives BYTES_PER_LINE + 1 results
// through the one frame store read port, one byte a cycle while the result queue has room;
// a blank-line tick gives a single result. reset: config registers take their defaults,
// line state clears, and the frame store is zeroed over all BYTES_PER_LINE * STORED_LINES
// bytes (880 by default) while s_axis_tready stays low; config writes are taken throughout
module ntsc_line_timing_and_pixel_fetch_top import ntlt_pkg::*; #(
	parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF,
	parameter int STORED_LINES   = STORED_LINES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // write_address[9:0], write_data[17:10]
	input  logic                   s_axis_tuser,   // func
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // line_number[8:0], sync_width[18:9],
	                                               // pixel_byte[26:19]
	output logic                   m_axis_tuser,   // pixel_valid
	output logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int OUT_PAD_W = OUT_TDATA_W - LINE_W - SYNC_W - PIX_W;

	cfg_t      cfg_q;
	logic      clearing;
	logic      q_valid;
	q_item_t   q_item;
	logic      q_pop;
	out_item_t m_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hsync_width   <= HSYNC_RESET;
			cfg_q.vsync_width   <= VSYNC_RESET;
			cfg_q.line_repeat   <= REPEAT_RESET;
			cfg_q.invert_pixels <= INVERT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_HSYNC_WIDTH: begin
					cfg_q.hsync_width <= cfg_data;
				end
				REG_VSYNC_WIDTH: begin
					cfg_q.vsync_width <= cfg_data;
				end
				REG_LINE_REPEAT: begin
					cfg_q.line_repeat <= cfg_data[REP_W-1:0];
				end
				REG_INVERT_PIXELS: begin
					cfg_q.invert_pixels <= cfg_data[0];
				end
			endcase
		end
	end

	ntlt_front #(
		.STORE_BYTES(BYTES_PER_LINE * STORED_LINES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_func  (s_axis_tuser),
		.s_addr  (s_axis_tdata[IN_ADDR_W-1:0]),
		.s_data  (s_axis_tdata[IN_ADDR_W +: PIX_W]),
		.clearing(clearing),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	ntlt_back #(
		.BYTES_PER_LINE(BYTES_PER_LINE),
		.STORED_LINES  (STORED_LINES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.clearing(clearing),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_item  (m_item)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, m_item.pixel_byte, m_item.sync_width,
		m_item.line_number};
	assign m_axis_tuser = m_item.pixel_valid;
	assign m_axis_tlast = m_item.last;

endmodule

// ----- src/ntlt_chk.sv -----
// port-level checks on the result stream of the scan-line timing and pixel fetch block
// depends on ntlt_pkg and the assertion macro header; bound to the top level below
`include "ntsc_line_timing_and_pixel_fetch_top_defines.svh"

module ntlt_chk import ntlt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser,
	input logic                   m_axis_tlast
);

	// a stalled result holds
	`NTLT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

	// only visible lines produce more than one result
	`NTLT_ASSERT_IMPLY(a_multi_visible, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser, "non-final result on a blank line")

	// video only on visible lines
	`NTLT_ASSERT_IMPLY(a_visible_range, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[LINE_W-1:0] < LINE_W'(VISIBLE_LINES), "pixel data on a line outside the visible range")

	// the final result of a tick carries a zero byte
	`NTLT_ASSERT_IMPLY(a_last_zero, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[LINE_W + SYNC_W +: PIX_W] == '0, "closing byte not zero")

endmodule

bind ntsc_line_timing_and_pixel_fetch_top ntlt_chk u_ntlt_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
